@@ rtl/core/nsdpp_pkg.sv @@
// Shared types and constants for the noise-shaped dither PCM packer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package nsdpp_pkg;

	localparam int unsigned SAMPLE_W = 24;
	localparam int unsigned ERR_W    = 32;
	localparam int unsigned CFG_W    = 2;

	// LCG constants for the per-channel dither generator
	localparam logic [31:0] LCG_MUL    = 32'h0019660D;
	localparam logic [31:0] LCG_INC    = 32'h3C6EF35F;
	localparam logic [7:0]  OFFSET_XOR = 8'h80;

	// Configuration register indexes
	localparam logic [CFG_W-1:0] REG_SOURCE_BYTES  = 2'd0;
	localparam logic [CFG_W-1:0] REG_TARGET_BYTES  = 2'd1;
	localparam logic [CFG_W-1:0] REG_CHANNEL_COUNT = 2'd2;

	// Effective sample widths in bytes (already mapped 0 -> 1)
	typedef struct packed {
		logic [CFG_W-1:0] src_bytes;
		logic [CFG_W-1:0] tgt_bytes;
	} width_cfg_t;

	// Error feedback and dither seed of one channel
	typedef struct packed {
		logic [ERR_W-1:0] e_newest;
		logic [ERR_W-1:0] e_middle;
		logic [ERR_W-1:0] e_oldest;
		logic [31:0]      seed;
	} chan_state_t;

	// Packed little-endian result
	typedef struct packed {
		logic [7:0]       byte_low;
		logic [7:0]       byte_mid;
		logic [7:0]       byte_high;
		logic [CFG_W-1:0] byte_count;
	} pack_t;

endpackage

@@ rtl/core/nsdpp_in_if.sv @@
// Input sample channel: valid/ready handshake with sample and block_end payload.
// Depends on nsdpp_pkg for the sample width.
`timescale 1ns / 1ps

interface nsdpp_in_if import nsdpp_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       block_end;

	modport source (output valid, output sample, output block_end, input ready);
	modport sink   (input valid, input sample, input block_end, output ready);
endinterface

@@ rtl/core/nsdpp_out_if.sv @@
// Output byte channel: valid/ready handshake with the packed bytes and byte count.
// Depends on nsdpp_pkg for the count width.
`timescale 1ns / 1ps

interface nsdpp_out_if import nsdpp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [7:0]       byte_low;
	logic [7:0]       byte_mid;
	logic [7:0]       byte_high;
	logic [CFG_W-1:0] byte_count;

	modport source (output valid, output byte_low, output byte_mid, output byte_high,
		output byte_count, input ready);
	modport sink   (input valid, input byte_low, input byte_mid, input byte_high,
		input byte_count, output ready);
endinterface

@@ rtl/core/nsdpp_requant.sv @@
// Combinational requantizer: noise shaping, TPDF dither, clip, floor and byte packing.
// Depends on nsdpp_pkg for the state, config and result types.
`timescale 1ns / 1ps

module nsdpp_requant import nsdpp_pkg::*; (
	input  logic signed [SAMPLE_W-1:0] sample,
	input  width_cfg_t                 wcfg,
	input  chan_state_t                st,
	output chan_state_t                st_next,
	output logic                       upd,
	output pack_t                      res
);

	logic               scale16;
	logic [15:0]        mask16;
	logic [31:0]        new_r;
	logic signed [35:0] x_w, e0_w, e1_w, e2_w;
	logic signed [35:0] s_w, s_c, out_w, out_c, out_f;
	logic signed [35:0] maxv, minv, bias, dith, diff;
	logic [31:0]        e_half;
	logic [23:0]        y;

	assign new_r = 32'(st.seed * LCG_MUL) + LCG_INC;

	always_comb begin
		upd     = wcfg.tgt_bytes < wcfg.src_bytes;
		scale16 = (wcfg.src_bytes == 2'd3) && (wcfg.tgt_bytes == 2'd1);
		mask16  = scale16 ? 16'hFFFF : 16'h00FF;
		bias    = scale16 ? 36'sd32768 : 36'sd128;

		case (wcfg.src_bytes)
			2'd1:    maxv = 36'sd127;
			2'd2:    maxv = 36'sd32767;
			default: maxv = 36'sd8388607;
		endcase
		minv = ~maxv;

		x_w  = {{12{sample[23]}}, sample};
		e0_w = {{4{st.e_newest[31]}}, st.e_newest};
		e1_w = {{4{st.e_middle[31]}}, st.e_middle};
		e2_w = {{4{st.e_oldest[31]}}, st.e_oldest};
		s_w  = x_w + e0_w - e1_w + e2_w;

		dith  = $signed({20'd0, new_r[15:0] & mask16}) - $signed({20'd0, st.seed[15:0] & mask16});
		out_w = s_w + bias + dith;

		// clip the output; pull the shaped sample along when it is past the same limit
		out_c = out_w;
		s_c   = s_w;
		if (out_w > maxv) begin
			out_c = maxv;
			if (s_w > maxv) s_c = maxv;
		end else if (out_w < minv) begin
			out_c = minv;
			if (s_w < minv) s_c = minv;
		end

		out_f = out_c & ~{20'd0, mask16};
		diff  = s_c - out_f;

		// halve toward zero
		e_half = 32'($signed(st.e_newest + {31'd0, st.e_newest[31]}) >>> 1);

		st_next.e_newest = diff[31:0];
		st_next.e_middle = e_half;
		st_next.e_oldest = st.e_middle;
		st_next.seed     = new_r;

		if (!upd) begin
			y = sample;
		end else if (scale16) begin
			y = {{16{out_f[23]}}, out_f[23:16]};
		end else begin
			y = {{8{out_f[23]}}, out_f[23:8]};
		end

		res.byte_count = wcfg.tgt_bytes;
		if (wcfg.tgt_bytes == 2'd1) begin
			res.byte_low  = y[7:0] ^ OFFSET_XOR;
			res.byte_mid  = 8'd0;
			res.byte_high = 8'd0;
		end else begin
			res.byte_low  = y[7:0];
			res.byte_mid  = y[15:8];
			res.byte_high = (wcfg.tgt_bytes == 2'd3) ? y[23:16] : 8'd0;
		end
	end

endmodule

@@ rtl/core/noise_shaped_dither_pcm_packer_unit.sv @@
// Noise-shaped TPDF dither requantizer and little-endian PCM packer, top level.
// An accepted beat passes through the input stage and the result register to out_ch.
// Throughput: one beat per cycle while out_ch does not stall; the per-channel feedback
// state is read, and rewritten when a beat requantizes, between those two registers.
// Reset: config reads source 2 bytes, target 2 bytes, 2 channels; all channel state,
// the channel toggle and both valid flags clear.
`timescale 1ns / 1ps

module noise_shaped_dither_pcm_packer_unit import nsdpp_pkg::*; #(
	parameter int unsigned MAX_CHANNELS = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata,
	nsdpp_in_if.sink          in_ch,
	nsdpp_out_if.source       out_ch
);

	localparam int unsigned CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	// configuration registers
	logic [CFG_W-1:0] source_bytes_q, target_bytes_q, channel_count_q;

	// input stage
	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic                       block_end_s1;

	// per-channel state and channel toggle
	chan_state_t state_q [MAX_CHANNELS];
	logic        toggle_q;

	// result register
	logic  valid_s2;
	pack_t res_s2;

	width_cfg_t  wcfg;
	chan_state_t st_cur, st_next;
	logic        upd;
	pack_t       res;
	logic        advance;
	logic        two_chan;
	logic [CH_W-1:0] ch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_bytes_q  <= 2'd2;
			target_bytes_q  <= 2'd2;
			channel_count_q <= 2'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SOURCE_BYTES:  source_bytes_q  <= cfg_wdata;
				REG_TARGET_BYTES:  target_bytes_q  <= cfg_wdata;
				REG_CHANNEL_COUNT: channel_count_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// map a zero width to one byte; counts of 2 or 3 mean two channels
	assign wcfg.src_bytes = (source_bytes_q == 2'd0) ? 2'd1 : source_bytes_q;
	assign wcfg.tgt_bytes = (target_bytes_q == 2'd0) ? 2'd1 : target_bytes_q;
	assign two_chan       = (MAX_CHANNELS > 1) && channel_count_q[1];

	// advance the input stage whenever the result register is free or being drained
	assign advance     = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			sample_s1    <= in_ch.sample;
			block_end_s1 <= in_ch.block_end;
		end
	end

	assign ch     = CH_W'(toggle_q);
	assign st_cur = state_q[ch];

	nsdpp_requant u_requant (
		.sample  (sample_s1),
		.wcfg    (wcfg),
		.st      (st_cur),
		.st_next (st_next),
		.upd     (upd),
		.res     (res)
	);

	// write back the channel state only when a beat really requantizes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				state_q[i] <= '0;
			end
		end else if (advance && upd) begin
			state_q[ch] <= st_next;
		end
	end

	// toggle advances on every beat with two channels; block end drops it to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			toggle_q <= 1'b0;
		end else if (advance) begin
			if (block_end_s1) begin
				toggle_q <= 1'b0;
			end else if (two_chan) begin
				toggle_q <= ~toggle_q;
			end else begin
				toggle_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_ch.valid      = valid_s2;
	assign out_ch.byte_low   = res_s2.byte_low;
	assign out_ch.byte_mid   = res_s2.byte_mid;
	assign out_ch.byte_high  = res_s2.byte_high;
	assign out_ch.byte_count = res_s2.byte_count;

	a_block_end_clears_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && block_end_s1) |=> !toggle_q)
		else $error("channel toggle not cleared after block end");

	a_passthrough_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !upd) |=> (state_q[0] == $past(state_q[0]))
			&& (state_q[MAX_CHANNELS-1] == $past(state_q[MAX_CHANNELS-1])))
		else $error("channel state changed on passthrough beat");

	a_advance_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advanced beat did not reach the result register");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_s2.byte_count != 2'd0))
		else $error("result carries zero byte count");

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking bench for the noise-shaped dither PCM packer top level.
// Needs nsdpp_pkg, nsdpp_in_if, nsdpp_out_if and the unit itself; it reads nothing else.
`timescale 1ns / 1ps

module testbench;
	import nsdpp_pkg::*;

	localparam int unsigned HALF_PERIOD  = 4;
	localparam int unsigned CYCLE_LIMIT  = 300000;
	localparam int unsigned RANDOM_BEATS = 1000;
	localparam int unsigned HOLD_CYCLES  = 300;

	typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_MOSTLY} rx_mode_t;
	typedef enum {STY_UNIFORM, STY_QUIET, STY_LOUD, STY_WILD} sample_style_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	nsdpp_in_if  in_if ();
	nsdpp_out_if out_if ();

	noise_shaped_dither_pcm_packer_unit #(
		.MAX_CHANNELS(2)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_if),
		.out_ch   (out_if)
	);

	// Shadow copy of the configuration registers, updated on the write edge
	logic [CFG_W-1:0] shadow_src;
	logic [CFG_W-1:0] shadow_tgt;
	logic [CFG_W-1:0] shadow_chans;

	// Per-channel error feedback and dither seeds, plus the channel toggle
	logic [31:0] fb_newest [2];
	logic [31:0] fb_middle [2];
	logic [31:0] fb_oldest [2];
	logic [31:0] dither_seed [2];
	bit          chan_sel;

	pack_t expected_packs [$];
	int    fail_count;
	int    cycle_count;

	// Sender pacing
	bit pace_gaps;
	int burst_left;

	// Receiver pacing; the long hold is requested by bumping hold_seq
	int       hold_seq;
	int       rx_seen_seq;
	int       rx_hold_left;
	int       rx_stretch_left;
	int       rx_phase;
	rx_mode_t rx_mode;

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Watchdog: a run that stalls or loses a beat ends here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d beats still expected", $time, expected_packs.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic int unsigned eff_bytes(logic [CFG_W-1:0] r);
		return (r == 0) ? 1 : r;
	endfunction

	function automatic logic [23:0] sext_at(logic [23:0] v, int unsigned nbytes);
		case (nbytes)
			1: return {{16{v[7]}}, v[7:0]};
			2: return {{8{v[15]}}, v[15:0]};
			default: return v;
		endcase
	endfunction

	// Shape, dither, clip and floor one sample on channel ch; advance its state
	function automatic longint requant(int ch, longint x, int sbits, int tbits);
		int          scale;
		longint      mask, maxv, minv, e0, e1, e2, s, q;
		logic [31:0] r_old, r_new;
		scale = sbits - tbits;
		mask  = (longint'(1) << scale) - 1;
		maxv  = (longint'(1) << (sbits - 1)) - 1;
		minv  = -(longint'(1) << (sbits - 1));
		e0    = {{32{fb_newest[ch][31]}}, fb_newest[ch]};
		e1    = {{32{fb_middle[ch][31]}}, fb_middle[ch]};
		e2    = {{32{fb_oldest[ch][31]}}, fb_oldest[ch]};
		s     = x + e0 - e1 + e2;
		r_old = dither_seed[ch];
		r_new = r_old * LCG_MUL + LCG_INC;
		fb_oldest[ch] = fb_middle[ch];
		fb_middle[ch] = 32'(e0 / 2);
		q = s + (longint'(1) << (scale - 1));
		q = q + (longint'({32'd0, r_new}) & mask) - (longint'({32'd0, r_old}) & mask);
		dither_seed[ch] = r_new;
		// a clipped output also clips the shaped sample seen by the feedback
		if (q > maxv) begin
			q = maxv;
			if (s > maxv)
				s = maxv;
		end else if (q < minv) begin
			q = minv;
			if (s < minv)
				s = minv;
		end
		q = q - (q & mask);
		fb_newest[ch] = 32'(s - q);
		return q >>> scale;
	endfunction

	// Expected packed bytes for one accepted beat; advance the channel toggle
	function automatic pack_t predict_beat(logic [23:0] smp, bit be);
		int unsigned sb, tb, nch;
		int          ch;
		longint      x, y;
		logic [31:0] u;
		pack_t       p;
		sb  = eff_bytes(shadow_src);
		tb  = eff_bytes(shadow_tgt);
		nch = (shadow_chans == 0) ? 1 : ((shadow_chans > 2) ? 2 : shadow_chans);
		ch  = chan_sel;
		x   = {{40{smp[23]}}, smp};
		// equal or wider target passes the sample through untouched
		y   = (tb >= sb) ? x : requant(ch, x, sb * 8, tb * 8);
		u   = y[31:0];
		p.byte_count = CFG_W'(tb);
		if (tb == 1) begin
			p.byte_low  = u[7:0] ^ OFFSET_XOR;
			p.byte_mid  = 8'h00;
			p.byte_high = 8'h00;
		end else begin
			p.byte_low  = u[7:0];
			p.byte_mid  = u[15:8];
			p.byte_high = (tb == 3) ? u[23:16] : 8'h00;
		end
		if (be)
			chan_sel = 1'b0;
		else if (nch == 2)
			chan_sel = ~chan_sel;
		else
			chan_sel = 1'b0;
		return p;
	endfunction

	function automatic logic [23:0] gen_sample(sample_style_t style);
		int unsigned sb;
		int          full;
		int          k;
		logic [23:0] v;
		sb   = eff_bytes(shadow_src);
		full = 1 << (sb * 8 - 1);
		k    = $urandom_range(0, 15);
		v    = 24'($urandom);
		case (style)
			STY_QUIET: v = 24'(int'($urandom_range(0, 64)) - 32);
			// hug the rails so the clip and its feedback clamp get exercised
			STY_LOUD: v = $urandom_range(0, 1) ? 24'(full - 1 - k) : 24'(k - full);
			// mostly in range, now and then the raw 24-bit field
			STY_WILD: if ($urandom_range(0, 3) != 0) v = sext_at(v, sb);
			default: v = sext_at(v, sb);
		endcase
		return v;
	endfunction

	task automatic check_field(string fname, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
			fail_count++;
		end
	endtask

	// Compare every result beat against the oldest prediction
	always @(posedge clk) begin
		pack_t want;
		if (arst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
			if (expected_packs.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual %h %h %h count %0d",
					$time, out_if.byte_low, out_if.byte_mid, out_if.byte_high,
					out_if.byte_count);
				fail_count++;
			end else begin
				want = expected_packs.pop_front();
				check_field("byte_low", want.byte_low, out_if.byte_low);
				check_field("byte_mid", want.byte_mid, out_if.byte_mid);
				check_field("byte_high", want.byte_high, out_if.byte_high);
				check_field("byte_count", 8'(want.byte_count), 8'(out_if.byte_count));
			end
		end
	end

	// Receiver: stall on changing patterns; hold off entirely when a hold is requested
	always @(negedge clk) begin
		rx_phase++;
		if (hold_seq != rx_seen_seq) begin
			rx_seen_seq  = hold_seq;
			rx_hold_left = HOLD_CYCLES;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			out_if.ready <= 1'b0;
		end else begin
			if (rx_stretch_left == 0) begin
				rx_mode         = rx_mode_t'($urandom_range(0, 3));
				rx_stretch_left = $urandom_range(8, 64);
			end
			rx_stretch_left--;
			case (rx_mode)
				RX_OPEN:     out_if.ready <= 1'b1;
				RX_COIN:     out_if.ready <= 1'($urandom_range(0, 1));
				RX_PERIODIC: out_if.ready <= (rx_phase % 3 == 0);
				default:     out_if.ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// Offer one beat, hold it until accepted, then record its prediction
	task automatic send_beat(logic [23:0] smp, bit be);
		int gap;
		if (pace_gaps && burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 16) : $urandom_range(1, 3);
			repeat (gap) begin
				@(negedge clk);
				in_if.valid <= 1'b0;
			end
			// long bursts leave stretches with no sender idling
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90)
				: $urandom_range(1, 12);
		end
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
		in_if.valid     <= 1'b1;
		in_if.sample    <= smp;
		in_if.block_end <= be;
		@(posedge clk);
		while (in_if.ready !== 1'b1)
			@(posedge clk);
		expected_packs.push_back(predict_beat(smp, be));
	endtask

	// Drop valid, wait for every expected beat, then let the pipeline empty
	task automatic settle_idle();
		@(negedge clk);
		in_if.valid <= 1'b0;
		while (expected_packs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_SOURCE_BYTES:  shadow_src   = val;
			REG_TARGET_BYTES:  shadow_tgt   = val;
			REG_CHANNEL_COUNT: shadow_chans = val;
			default: ;
		endcase
	endtask

	// Reprogram all three registers, only ever while the block is idle
	task automatic apply_setting(logic [CFG_W-1:0] src, logic [CFG_W-1:0] tgt,
		logic [CFG_W-1:0] chans);
		settle_idle();
		write_reg(REG_SOURCE_BYTES, src);
		write_reg(REG_TARGET_BYTES, tgt);
		write_reg(REG_CHANNEL_COUNT, chans);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Reset configuration is 16 to 16 bits: the beat passes straight through
	task automatic test_reset_defaults();
		send_beat(24'h7FFFFF, 1'b0);
		send_beat(24'h800000, 1'b0);
		send_beat(24'h000000, 1'b1);
	endtask

	// Narrowing at the rails, out-of-range input and odd channel counts
	task automatic test_narrowing();
		apply_setting(2'd3, 2'd1, 2'd2);
		send_beat(24'h7FFFFF, 1'b0);
		send_beat(24'h800000, 1'b0);
		send_beat(24'h000000, 1'b0);
		send_beat(24'h7FFFFF, 1'b1);
		// channel count three acts as two; the last sample lies outside 16 bits
		apply_setting(2'd2, 2'd1, 2'd3);
		send_beat(24'h007FFF, 1'b0);
		send_beat(24'hFF8000, 1'b0);
		send_beat(24'h5A5A5A, 1'b1);
		// channel count zero acts as one
		apply_setting(2'd3, 2'd2, 2'd0);
		send_beat(24'h7FFFF0, 1'b0);
		send_beat(24'h800010, 1'b0);
		send_beat(24'h000001, 1'b1);
	endtask

	// Zero width registers, a wider target, and block_end closing a channel pair
	task automatic test_special_settings();
		apply_setting(2'd0, 2'd0, 2'd1);
		send_beat(24'h00007F, 1'b0);
		send_beat(24'hFFFF80, 1'b0);
		apply_setting(2'd1, 2'd3, 2'd2);
		send_beat(24'h800000, 1'b0);
		send_beat(24'h7FFFFF, 1'b0);
		apply_setting(2'd2, 2'd1, 2'd2);
		send_beat(24'h001234, 1'b0);
		send_beat(24'hFFEDCC, 1'b1);
		send_beat(24'h000100, 1'b0);
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering beats
	task automatic test_backpressure();
		apply_setting(2'd3, 2'd1, 2'd2);
		pace_gaps = 1'b0;
		hold_seq++;
		repeat (120)
			send_beat(gen_sample(STY_LOUD), ($urandom_range(0, 15) == 0));
		pace_gaps = 1'b1;
	endtask

	// Phases of random beats, each under its own setting; extremes come first
	task automatic test_random_settings();
		int               sent;
		int               phase;
		int               n;
		logic [CFG_W-1:0] s, t, c;
		sample_style_t    style;
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_BEATS) begin
			case (phase)
				0: begin s = 2'd3; t = 2'd1; c = 2'd2; end
				1: begin s = 2'd3; t = 2'd1; c = 2'd1; end
				2: begin s = 2'd2; t = 2'd1; c = 2'd0; end
				3: begin s = 2'd3; t = 2'd2; c = 2'd3; end
				4: begin s = 2'd1; t = 2'd3; c = 2'd2; end
				default: begin
					// favor narrowing, where the feedback state matters
					if ($urandom_range(0, 9) < 7) begin
						s = CFG_W'($urandom_range(2, 3));
						t = CFG_W'($urandom_range(0, s - 1));
					end else begin
						s = CFG_W'($urandom_range(0, 3));
						t = CFG_W'($urandom_range(0, 3));
					end
					c = CFG_W'($urandom_range(0, 3));
				end
			endcase
			apply_setting(s, t, c);
			style = sample_style_t'($urandom_range(0, 3));
			n = (eff_bytes(t) >= eff_bytes(s)) ? $urandom_range(10, 30)
				: $urandom_range(60, 140);
			repeat (n)
				send_beat(gen_sample(style), ($urandom_range(0, 11) == 0));
			sent += n;
			phase++;
		end
	endtask

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_wdata       = '0;
		in_if.valid     = 1'b0;
		in_if.sample    = '0;
		in_if.block_end = 1'b0;
		out_if.ready    = 1'b0;
		shadow_src      = 2'd2;
		shadow_tgt      = 2'd2;
		shadow_chans    = 2'd2;
		for (int i = 0; i < 2; i++) begin
			fb_newest[i]   = '0;
			fb_middle[i]   = '0;
			fb_oldest[i]   = '0;
			dither_seed[i] = '0;
		end
		chan_sel        = 1'b0;
		fail_count      = 0;
		cycle_count     = 0;
		pace_gaps       = 1'b1;
		burst_left      = 0;
		hold_seq        = 0;
		rx_seen_seq     = 0;
		rx_hold_left    = 0;
		rx_stretch_left = 0;
		rx_phase        = 0;
		rx_mode         = RX_OPEN;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_narrowing();
		test_special_settings();
		test_backpressure();
		test_random_settings();
		settle_idle();

		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
